// ===== design/gfa_pkg.sv =====
// goldilocks field alu package: opcodes, prime constant and field helper functions
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package gfa_pkg;
    localparam logic [63:0] GL_P = 64'hffff_ffff_0000_0001;
    localparam logic [63:0] LO32 = 64'h0000_0000_ffff_ffff;

    // stage 0 input registers up to the output register, and the select stage
    localparam int GFA_STAGES = 17;
    localparam int GFA_SEL    = GFA_STAGES - 2;

    localparam logic [3:0] OP_NEG        = 4'd0;
    localparam logic [3:0] OP_ADD        = 4'd1;
    localparam logic [3:0] OP_SUB        = 4'd2;
    localparam logic [3:0] OP_SUB_SAFE   = 4'd3;
    localparam logic [3:0] OP_MUL        = 4'd4;
    localparam logic [3:0] OP_MUL_ADD    = 4'd5;
    localparam logic [3:0] OP_SQR        = 4'd6;
    localparam logic [3:0] OP_SQR_ADD    = 4'd7;
    localparam logic [3:0] OP_SQR_ADD_P  = 4'd8;
    localparam logic [3:0] OP_MUL_SMALL  = 4'd9;
    localparam logic [3:0] OP_SBOX       = 4'd10;
    localparam logic [3:0] OP_RED        = 4'd11;
    localparam logic [3:0] OP_RED_P      = 4'd12;
    localparam logic [3:0] OP_RED_SMALL  = 4'd13;

    function automatic logic [63:0] f_neg(input logic [63:0] x);
        return (x == 64'd0) ? 64'd0 : GL_P - x;
    endfunction

    function automatic logic [63:0] f_add(input logic [63:0] x, input logic [63:0] y);
        logic [64:0] z;
        z = {1'b0, x} + {1'b0, y};
        return (z[64] || z[63:0] >= GL_P) ? z[63:0] - GL_P : z[63:0];
    endfunction

    function automatic logic [63:0] f_sub(input logic [63:0] x, input logic [63:0] y);
        logic [63:0] z;
        z = x - y;
        return (z > x) ? z + GL_P : z;
    endfunction

    function automatic logic [63:0] fold_partial(input logic [63:0] hi,
                                                 input logic [63:0] lo);
        logic [63:0] n1, n2, t, r;
        n1 = hi & LO32;
        n2 = hi >> 32;
        t = lo + ((n1 << 32) - n1);
        if (t < lo) t = t - GL_P;
        r = t - n2;
        if (r > t) r = r + GL_P;
        return r;
    endfunction

    function automatic logic [63:0] fold_small(input logic [63:0] hi, input logic [63:0] lo);
        logic [63:0] t;
        t = lo + ((hi << 32) - hi);
        if (t < lo) t = t - GL_P;
        return (t >= GL_P) ? t - GL_P : t;
    endfunction

    function automatic logic [63:0] canon(input logic [63:0] r);
        return (r >= GL_P) ? r - GL_P : r;
    endfunction

    typedef struct packed {
        logic [3:0]  opcode;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] zl;
        logic [63:0] zh;
    } t_op;
endpackage
`default_nettype wire

// ===== design/gfa_if.sv =====
// valid/ready channel interfaces for the goldilocks field alu
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none
interface gfa_in_if;
    logic        valid;
    logic        ready;
    logic [3:0]  opcode;
    logic [63:0] operand_a;
    logic [63:0] operand_b;
    logic [63:0] addend_low;
    logic [63:0] addend_high;
    modport source (output valid, opcode, operand_a, operand_b, addend_low, addend_high,
                    input ready);
    modport sink (input valid, opcode, operand_a, operand_b, addend_low, addend_high,
                  output ready);
endinterface

interface gfa_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] result;
    modport source (output valid, result, input ready);
    modport sink (input valid, result, output ready);
endinterface
`default_nettype wire

// ===== design/gfa_mulred.sv =====
// one pipelined multiply and fold: a*b + {zh,zl} over three stages
// stage one 32x32 partial products, stage two 128-bit sum, stage three fold; uses gfa_pkg
`timescale 1ns / 1ps
`default_nettype none
module gfa_mulred
    import gfa_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_en,
    input  wire         i_small,
    input  wire  [63:0] i_a,
    input  wire  [63:0] i_b,
    input  wire  [63:0] i_zl,
    input  wire  [63:0] i_zh,
    output logic [63:0] o_res
);
    logic [63:0] r_p00, r_p01, r_p10, r_p11, r_zl, r_zh;
    logic [63:0] r_lo, r_hi;
    logic        r_small1, r_small2;
    logic [63:0] n_lo, n_hi, w_mid, w_l;

    always_comb begin
        w_mid = (r_p00 >> 32) + (r_p01 & LO32) + (r_p10 & LO32);
        w_l   = (r_p00 & LO32) | (w_mid << 32);
        n_hi  = r_p11 + (r_p01 >> 32) + (r_p10 >> 32) + (w_mid >> 32);
        n_lo  = w_l + r_zl;
        n_hi  = n_hi + r_zh + {63'd0, (n_lo < r_zl)};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p00    <= {32'd0, i_a[31:0]}  * {32'd0, i_b[31:0]};
            r_p01    <= {32'd0, i_a[31:0]}  * {32'd0, i_b[63:32]};
            r_p10    <= {32'd0, i_a[63:32]} * {32'd0, i_b[31:0]};
            r_p11    <= {32'd0, i_a[63:32]} * {32'd0, i_b[63:32]};
            r_zl     <= i_zl;
            r_zh     <= i_zh;
            r_small1 <= i_small;
            r_lo     <= n_lo;
            r_hi     <= n_hi;
            r_small2 <= r_small1;
            o_res    <= r_small2 ? fold_small(r_hi, r_lo) : fold_partial(r_hi, r_lo);
        end
    end
endmodule
`default_nettype wire

// ===== design/goldilocks_field_alu.sv =====
// goldilocks field alu top level: input stage, four chained multiply units, result stage
// depends on gfa_pkg, gfa_if, gfa_mulred
//
//  channel   dir  beat contents
//  in_ch     in   opcode, operand_a, operand_b, addend_low, addend_high
//  out_ch    out  result
//
// one beat per cycle while the output register is empty or taken; every opcode takes
// the same path (sbox sets it: input stage, three multiply units of three stages plus a
// canon register each, a fourth multiply unit, then the output register); others ride along.
// the whole pipe advances when the output register is empty or taken; a stall freezes
// every stage. reset clears the valid bits only.
`timescale 1ns / 1ps
`default_nettype none
module goldilocks_field_alu
    import gfa_pkg::*;
(
    input  wire       i_clk,
    input  wire       i_rst_n,
    gfa_in_if.sink    in_ch,
    gfa_out_if.source out_ch
);
    logic                  w_en;
    logic [GFA_STAGES-1:0] r_vld;
    t_op                   r_op;
    logic [63:0]           r_t;
    logic [3:0]            r_code [1:GFA_SEL];
    logic [63:0]           r_w    [1:GFA_SEL];
    logic [63:0]           r_x2   [5:8];
    logic [63:0]           r_m1, r_m2, r_m3;
    logic [63:0]           r_res;
    logic [63:0]           n_early, n_mul1, n_res;
    logic [63:0]           w_a1, w_b1, w_zl1, w_zh1;
    logic                  w_small1;
    logic [63:0]           w_m1_p, w_m2_p, w_m3_p, w_m4_p;
    t_op                   w_in;

    // stage indexes: 0 input, 1..3 mul1, 4 x2, 5..7 mul2, 8 x4, 9..11 mul3, 12 x6,
    // 13..15 mul4 and select, 16 output
    assign w_en = !out_ch.valid || out_ch.ready;
    assign in_ch.ready = w_en;
    assign out_ch.valid = r_vld[GFA_STAGES-1];
    assign out_ch.result = r_res;
    assign w_in = '{in_ch.opcode, in_ch.operand_a, in_ch.operand_b,
                    in_ch.addend_low, in_ch.addend_high};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[GFA_STAGES-2:0], in_ch.valid};
        end
    end

    // first multiply: operand selection from stage 0, reductions go through as 0*0 + v
    always_comb begin
        w_a1 = r_op.a;
        w_b1 = r_op.b;
        w_zl1 = '0;
        w_zh1 = '0;
        case (r_op.opcode)
            OP_MUL_ADD: begin
                w_zl1 = r_op.zl;
                w_zh1 = r_op.zh;
            end
            OP_SQR: w_b1 = r_op.a;
            OP_SQR_ADD, OP_SQR_ADD_P: begin
                w_b1 = r_op.a;
                w_zl1 = r_op.b;
            end
            OP_MUL_SMALL: w_b1 = r_op.b & LO32;
            OP_SBOX: begin
                w_a1 = r_t;
                w_b1 = r_t;
            end
            OP_RED, OP_RED_P, OP_RED_SMALL: begin
                w_a1 = '0;
                w_b1 = '0;
                w_zl1 = r_op.zl;
                w_zh1 = r_op.zh;
            end
            default: ;
        endcase
    end

    assign w_small1 = (r_op.opcode == OP_MUL_SMALL) || (r_op.opcode == OP_RED_SMALL);

    // opcodes without a product finish here; sbox carries t on the same word
    always_comb begin
        case (r_op.opcode)
            OP_NEG:           n_early = f_neg(r_op.a);
            OP_ADD, OP_SBOX:  n_early = r_t;
            OP_SUB:           n_early = f_sub(r_op.a, r_op.b);
            OP_SUB_SAFE:      n_early = f_add(r_op.a, f_neg(r_op.b));
            default:          n_early = '0;
        endcase
    end

    // single product and reduce opcodes take their result from mul1
    always_comb begin
        case (r_code[3])
            OP_MUL, OP_MUL_ADD, OP_SQR, OP_SQR_ADD, OP_RED: n_mul1 = canon(w_m1_p);
            OP_SQR_ADD_P, OP_MUL_SMALL, OP_RED_P, OP_RED_SMALL: n_mul1 = w_m1_p;
            default: n_mul1 = r_w[3];
        endcase
    end

    assign n_res = (r_code[GFA_SEL] == OP_SBOX) ? canon(w_m4_p) : r_w[GFA_SEL];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_op <= w_in;
            r_t  <= f_add(in_ch.operand_a, in_ch.operand_b);
            r_code[1] <= r_op.opcode;
            r_w[1]    <= n_early;
            for (int i = 2; i <= GFA_SEL; i++) begin
                r_code[i] <= r_code[i-1];
            end
            for (int i = 2; i <= 3; i++) begin
                r_w[i] <= r_w[i-1];
            end
            r_w[4] <= n_mul1;
            for (int i = 5; i <= GFA_SEL; i++) begin
                r_w[i] <= r_w[i-1];
            end
            r_m1 <= canon(w_m1_p);
            r_x2[5] <= r_m1;
            for (int i = 6; i <= 8; i++) begin
                r_x2[i] <= r_x2[i-1];
            end
            r_m2 <= canon(w_m2_p);
            r_m3 <= canon(w_m3_p);
            r_res <= n_res;
        end
    end

    gfa_mulred u_m1 (.i_clk(i_clk), .i_en(w_en), .i_small(w_small1), .i_a(w_a1),
                     .i_b(w_b1), .i_zl(w_zl1), .i_zh(w_zh1), .o_res(w_m1_p));

    // x4 = x2*x2 from stage 4
    gfa_mulred u_m2 (.i_clk(i_clk), .i_en(w_en), .i_small(1'b0), .i_a(r_m1),
                     .i_b(r_m1), .i_zl(64'd0), .i_zh(64'd0), .o_res(w_m2_p));

    // x6 = x4*x2 from stage 8
    gfa_mulred u_m3 (.i_clk(i_clk), .i_en(w_en), .i_small(1'b0), .i_a(r_m2),
                     .i_b(r_x2[8]), .i_zl(64'd0), .i_zh(64'd0), .o_res(w_m3_p));

    // x7 = x6*t from stage 12, t rides on the carried word
    gfa_mulred u_m4 (.i_clk(i_clk), .i_en(w_en), .i_small(1'b0), .i_a(r_m3),
                     .i_b(r_w[12]), .i_zl(64'd0), .i_zh(64'd0), .o_res(w_m4_p));

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.result))
        else $error("held result changed");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_ch.ready == (!out_ch.valid || out_ch.ready))
        else $error("ready not tied to output drain");
    assert property (@(posedge i_clk)
        !i_rst_n |=> !out_ch.valid)
        else $error("result valid right after reset");
endmodule
`default_nettype wire

// ===== tb/tb.sv =====
// testbench for goldilocks_field_alu: directed table then random operations in idling phases
// depends on gfa_pkg, gfa_if and the design files
`timescale 1ns / 1ps
`default_nettype none
module tb
    import gfa_pkg::*;
();

    localparam int LATENCY = GFA_STAGES - 1;
    localparam int CYCLE_LIMIT = 400000;
    // opcodes with no operation behind them
    localparam logic [3:0] OP_SPARE_LO = 4'd14;
    localparam logic [3:0] OP_SPARE_HI = 4'd15;

    typedef struct {
        logic [3:0]  opcode;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] zl;
        logic [63:0] zh;
        bit          known;
        logic [63:0] res;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    gfa_in_if  in_ch();
    gfa_out_if out_ch();

    goldilocks_field_alu dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    always #4 i_clk = ~i_clk;

    logic [63:0] expected_results[$];
    int errors = 0;
    int results_seen = 0;
    int cycles = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int ops_sent = 0;

    // field arithmetic, written independently of the package
    function automatic logic [63:0] gl_reduce_part(input logic [63:0] hi, input logic [63:0] lo);
        logic [63:0] n1, t, r;
        n1 = {32'd0, hi[31:0]};
        t = lo + ((n1 << 32) - n1);
        if (t < lo) t = t - 64'hffff_ffff_0000_0001;
        r = t - {32'd0, hi[63:32]};
        if (r > t) r = r + 64'hffff_ffff_0000_0001;
        return r;
    endfunction

    function automatic logic [63:0] gl_canon(input logic [63:0] x);
        return (x >= 64'hffff_ffff_0000_0001) ? x - 64'hffff_ffff_0000_0001 : x;
    endfunction

    function automatic logic [63:0] gl_reduce_small(input logic [63:0] hi, input logic [63:0] lo);
        logic [63:0] t;
        t = lo + ((hi << 32) - hi);
        if (t < lo) t = t - 64'hffff_ffff_0000_0001;
        return gl_canon(t);
    endfunction

    function automatic logic [63:0] gl_negate(input logic [63:0] x);
        return (x == 64'd0) ? 64'd0 : 64'hffff_ffff_0000_0001 - x;
    endfunction

    function automatic logic [63:0] gl_sum(input logic [63:0] x, input logic [63:0] y);
        logic [63:0] z;
        z = x + y;
        return (z >= 64'hffff_ffff_0000_0001 || z < x) ? z - 64'hffff_ffff_0000_0001 : z;
    endfunction

    function automatic logic [63:0] gl_prod(input logic [63:0] x, input logic [63:0] y);
        logic [127:0] w;
        w = x * y;
        return gl_canon(gl_reduce_part(w[127:64], w[63:0]));
    endfunction

    function automatic logic [63:0] alu_result(input t_row r);
        logic [127:0] w;
        logic [63:0] t, x2, x4;
        case (r.opcode)
            OP_NEG:       return gl_negate(r.a);
            OP_ADD:       return gl_sum(r.a, r.b);
            OP_SUB: begin
                t = r.a - r.b;
                return (t > r.a) ? t + 64'hffff_ffff_0000_0001 : t;
            end
            OP_SUB_SAFE:  return gl_sum(r.a, gl_negate(r.b));
            OP_MUL:       return gl_prod(r.a, r.b);
            OP_MUL_ADD: begin
                w = r.a * r.b + {r.zh, r.zl};
                return gl_canon(gl_reduce_part(w[127:64], w[63:0]));
            end
            OP_SQR:       return gl_prod(r.a, r.a);
            OP_SQR_ADD: begin
                w = r.a * r.a + {64'd0, r.b};
                return gl_canon(gl_reduce_part(w[127:64], w[63:0]));
            end
            OP_SQR_ADD_P: begin
                w = r.a * r.a + {64'd0, r.b};
                return gl_reduce_part(w[127:64], w[63:0]);
            end
            OP_MUL_SMALL: begin
                w = r.a * {96'd0, r.b[31:0]};
                return gl_reduce_small(w[127:64], w[63:0]);
            end
            OP_SBOX: begin
                t = gl_sum(r.a, r.b);
                x2 = gl_prod(t, t);
                x4 = gl_prod(x2, x2);
                return gl_prod(gl_prod(x4, x2), t);
            end
            OP_RED:       return gl_canon(gl_reduce_part(r.zh, r.zl));
            OP_RED_P:     return gl_reduce_part(r.zh, r.zl);
            OP_RED_SMALL: return gl_reduce_small(r.zh, r.zl);
            default:      return 64'd0;
        endcase
    endfunction

    function automatic logic [63:0] pick_word();
        logic [63:0] p;
        p = 64'hffff_ffff_0000_0001;
        case ($urandom_range(0, 9))
            0: return 64'd0;
            1: return 64'hffff_ffff_ffff_ffff;
            2: return p + 64'($urandom_range(0, 3)) - 64'd2;
            3: return 64'($urandom_range(0, 15));
            4: return {32'hffff_ffff, $urandom()};
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    function automatic t_row row(input logic [3:0] op, input logic [63:0] a, input logic [63:0] b,
                                 input logic [63:0] zl, input logic [63:0] zh,
                                 input bit known = 1'b0, input logic [63:0] res = 64'd0);
        t_row r;
        r.opcode = op; r.a = a; r.b = b; r.zl = zl; r.zh = zh;
        r.known = known; r.res = res;
        return r;
    endfunction

    // clock-edge driving of the input channel
    task automatic send_op(input t_row r);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.opcode      <= r.opcode;
        in_ch.operand_a   <= r.a;
        in_ch.operand_b   <= r.b;
        in_ch.addend_low  <= r.zl;
        in_ch.addend_high <= r.zh;
        expected_results.push_back(r.known ? r.res : alu_result(r));
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        ops_sent++;
    endtask

    task automatic random_phase(input int n, input int idle, input int stall);
        t_row r;
        send_idle_pct = idle;
        recv_stall_pct = stall;
        repeat (n) begin
            r = row(4'($urandom_range(0, 15)), pick_word(), pick_word(),
                    pick_word(), pick_word());
            send_op(r);
        end
    endtask

    // result side: random stalls, compare each beat with the oldest expectation
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                results_seen <= results_seen + 1;
                if (expected_results.size() == 0) begin
                    errors <= errors + 1;
                    $display("%0t: unexpected result %h", $time, out_ch.result);
                end else begin
                    if (out_ch.result !== expected_results[0]) begin
                        errors <= errors + 1;
                        $display("%0t: result mismatch expected %h actual %h",
                                 $time, expected_results[0], out_ch.result);
                    end
                    void'(expected_results.pop_front());
                end
            end
            out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end else begin
            out_ch.ready <= 1'b0;
        end
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("DONE: errors detected");
            $finish;
        end
    end

    t_row directed[$];
    logic [63:0] pm1;
    logic [63:0] ones;

    initial begin
        in_ch.valid = 1'b0;
        in_ch.opcode = OP_NEG;
        in_ch.operand_a = '0;
        in_ch.operand_b = '0;
        in_ch.addend_low = '0;
        in_ch.addend_high = '0;
        pm1 = GL_P - 64'd1;
        ones = 64'hffff_ffff_ffff_ffff;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, every opcode, partial results at or above p, wide small reduce
        directed.push_back(row(OP_NEG, 64'd0, 64'd0, 64'd0, 64'd0, 1'b1, 64'd0));
        directed.push_back(row(OP_NEG, 64'd1, 64'd0, 64'd0, 64'd0, 1'b1, pm1));
        directed.push_back(row(OP_NEG, ones, 64'd0, 64'd0, 64'd0));
        directed.push_back(row(OP_ADD, pm1, 64'd1, 64'd0, 64'd0, 1'b1, 64'd0));
        directed.push_back(row(OP_ADD, ones, ones, 64'd0, 64'd0));
        directed.push_back(row(OP_SUB, 64'd0, 64'd1, 64'd0, 64'd0, 1'b1, pm1));
        directed.push_back(row(OP_SUB, 64'd5, 64'd3, 64'd0, 64'd0, 1'b1, 64'd2));
        directed.push_back(row(OP_SUB_SAFE, 64'd0, ones, 64'd0, 64'd0));
        directed.push_back(row(OP_MUL, pm1, pm1, 64'd0, 64'd0, 1'b1, 64'd1));
        directed.push_back(row(OP_MUL, ones, ones, 64'd0, 64'd0));
        directed.push_back(row(OP_MUL_ADD, pm1, pm1, ones, ones));
        directed.push_back(row(OP_SQR, 64'd3, 64'd0, 64'd0, 64'd0, 1'b1, 64'd9));
        directed.push_back(row(OP_SQR_ADD, ones, ones, 64'd0, 64'd0));
        directed.push_back(row(OP_SQR_ADD_P, 64'd0, GL_P, 64'd0, 64'd0, 1'b1, GL_P));
        directed.push_back(row(OP_SQR_ADD_P, ones, pm1, 64'd0, 64'd0));
        directed.push_back(row(OP_MUL_SMALL, ones, ones, 64'd0, 64'd0));
        directed.push_back(row(OP_SBOX, 64'd1, 64'd1, 64'd0, 64'd0, 1'b1, 64'd128));
        directed.push_back(row(OP_SBOX, pm1, ones, 64'd0, 64'd0));
        directed.push_back(row(OP_RED, 64'd0, 64'd0, GL_P, 64'd0, 1'b1, 64'd0));
        directed.push_back(row(OP_RED, 64'd0, 64'd0, ones, ones));
        directed.push_back(row(OP_RED_P, 64'd0, 64'd0, ones, 64'd0, 1'b1, ones));
        directed.push_back(row(OP_RED_SMALL, 64'd0, 64'd0, 64'd7, ones));
        directed.push_back(row(OP_RED_SMALL, 64'd0, 64'd0, ones, 64'hffff_ffff));
        directed.push_back(row(OP_SPARE_LO, ones, 64'd1, 64'd1, 64'd1, 1'b1, 64'd0));
        directed.push_back(row(OP_SPARE_HI, 64'd1, 64'd1, 64'd1, 64'd1, 1'b1, 64'd0));
        foreach (directed[i]) send_op(directed[i]);

        random_phase(500, 0, 0);
        random_phase(350, 81, 0);
        // hold the sender until the pipe has drained
        in_ch.valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        random_phase(350, 0, 81);
        random_phase(400, 34, 34);
        random_phase(400, 0, 0);
        in_ch.valid <= 1'b0;
        recv_stall_pct = 20;

        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 5) @(posedge i_clk);
        $display("sent %0d operations (all opcodes incl. unused), checked %0d results",
                 ops_sent, results_seen);
        $display("phases: no idling, sender idle, receiver stall, both, back to back");
        if (errors == 0 && expected_results.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ===== filelist.f =====
design/gfa_pkg.sv
design/gfa_if.sv
design/gfa_mulred.sv
design/goldilocks_field_alu.sv
tb/tb.sv
